FILE: rtl/lru_block_cache_macros.svh
// Assertion macros shared by the cache RTL.
// Used by lru_block_cache.sv; expects a clock i_clk and a reset i_rst_n in scope.
`ifndef LRU_BLOCK_CACHE_MACROS_SVH
`define LRU_BLOCK_CACHE_MACROS_SVH

// Checks that a property holds on every clock edge outside reset.
`define LBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one on the following edge.
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lbc_pkg.sv
// Package for the block cache: sizes, widths, state encoding and shared structs.
// No dependencies; the interfaces, lru_block_cache, lbc_cell and lbc_chain import it.
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int NUM_BLOCKS    = 4096;
    localparam int CACHE_ENTRIES = 64;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int USED_W = $clog2(CACHE_ENTRIES + 1);
    localparam int CAP_W  = 7;
    localparam int DATA_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_lbc_state;

    typedef struct packed {
        logic              commit;
        logic              hit;
        logic [USED_W-1:0] used;
        logic [USED_W-1:0] limit;
        logic [BLK_W-1:0]  key;
    } t_cell_ctl;

    typedef struct packed {
        logic [BLK_W-1:0] tag;
        logic             found;
        logic [BLK_W-1:0] ev_tag;
    } t_link;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [BLK_W-1:0] evicted_block;
    } t_lookup;

endpackage

FILE: rtl/lbc_req_if.sv
// Request channel of the block cache: valid, ready and one access per beat.
// Depends on lbc_pkg for the field widths.
`timescale 1ns / 1ps

interface lbc_req_if import lbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BLK_W-1:0]  block_number;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output mode, output block_number, output write_data,
                    input ready);
    modport sink (input valid, input mode, input block_number, input write_data,
                  output ready);
endinterface

FILE: rtl/lbc_rsp_if.sv
// Response channel of the block cache: valid, ready and one result per beat.
// Depends on lbc_pkg for the field widths.
`timescale 1ns / 1ps

interface lbc_rsp_if import lbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              disk_read;
    logic              disk_write;
    logic              evicted;
    logic [BLK_W-1:0]  evicted_block;

    modport source (output valid, output read_data, output hit, output disk_read,
                    output disk_write, output evicted, output evicted_block,
                    input ready);
    modport sink (input valid, input read_data, input hit, input disk_read,
                  input disk_write, input evicted, input evicted_block,
                  output ready);
endinterface

FILE: rtl/lru_block_cache.sv
// Fully associative block cache with least-recently-used replacement.
// The request beat is taken in ST_IDLE; in ST_LOOK the lookup commits once the result register is free.
// A new request waits until the last one has committed in ST_LOOK, which waits out the registered store RAM read.
// Reset: a clearing pass writes zero to all 4096 store bytes, one per cycle, and
// no request is taken until the pass ends; capacity returns to 64.
`timescale 1ns / 1ps
`include "lru_block_cache_macros.svh"

module lru_block_cache import lbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lbc_req_if.sink          i_req,
    lbc_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_lbc_state        r_state;
    t_lbc_state        n_state;
    logic [BLK_W-1:0]  r_clr_addr;
    logic [CAP_W-1:0]  r_capacity;
    logic [USED_W-1:0] live_cap;

    logic              r_mode;
    logic [BLK_W-1:0]  r_blk;
    logic [DATA_W-1:0] r_wdata;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic              r_hit;
    logic              r_disk_read;
    logic              r_disk_write;
    logic              r_evicted;
    logic [BLK_W-1:0]  r_evicted_block;

    logic              accept;
    logic              commit;
    logic              ram_en;
    logic              ram_we;
    logic [BLK_W-1:0]  ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    t_lookup           lookup;

    always_comb begin
        if (r_capacity == '0) begin
            live_cap = USED_W'(1);
        end else if (int'(r_capacity) > CACHE_ENTRIES) begin
            live_cap = USED_W'(CACHE_ENTRIES);
        end else begin
            live_cap = USED_W'(r_capacity);
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        commit      = 1'b0;
        n_out_valid = r_out_valid && !o_rsp.ready;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = i_req.block_number;
        ram_wdata   = i_req.write_data;
        case (r_state)
            ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == BLK_W'(NUM_BLOCKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    ram_en  = 1'b1;
                    ram_we  = (i_req.mode == MODE_WRITE);
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || o_rsp.ready) begin
                    commit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + BLK_W'(1);
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_blk   <= i_req.block_number;
            r_wdata <= i_req.write_data;
        end
        if (commit) begin
            r_read_data     <= (r_mode == MODE_WRITE) ? r_wdata : ram_rdata;
            r_hit           <= lookup.hit;
            r_disk_read     <= !lookup.hit && (r_mode == MODE_READ);
            r_disk_write    <= !lookup.hit && (r_mode == MODE_WRITE);
            r_evicted       <= lookup.evicted;
            r_evicted_block <= lookup.evicted_block;
        end
    end

    lbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BLOCKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    lbc_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_blk),
        .i_cap    (live_cap),
        .i_commit (commit),
        .o_lookup (lookup)
    );

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_read_data;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.disk_read     = r_disk_read;
    assign o_rsp.disk_write    = r_disk_write;
    assign o_rsp.evicted       = r_evicted;
    assign o_rsp.evicted_block = r_evicted_block;

    `LBC_ASSERT_NEXT(a_accept_to_look, accept, r_state == ST_LOOK, "Request beat did not start a lookup.")
    `LBC_ASSERT(a_hit_no_evict, r_out_valid |-> !(r_hit && (r_evicted || r_disk_read || r_disk_write)), "Hit reported together with a miss action.")
    `LBC_ASSERT(a_miss_one_disk_op, (r_out_valid && !r_hit) |-> (r_disk_read ^ r_disk_write), "Miss must flag exactly one disk operation.")
    `LBC_ASSERT(a_result_from_look, $rose(r_out_valid) |-> ($past(r_state) == ST_LOOK), "Result beat appeared without a lookup.")

endmodule

FILE: rtl/lbc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lbc_cell.sv
// One recency cell: holds a tag, compares it with the key and takes its
// neighbor's tag when the row shifts. Depends on lbc_pkg.
`timescale 1ns / 1ps

module lbc_cell import lbc_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell_ctl        i_ctl,
    input  t_link            i_link,
    output t_link            o_link
);

    logic [BLK_W-1:0]  r_tag;
    logic [BLK_W-1:0]  n_tag;
    logic [USED_W-1:0] pos;
    logic              valid;
    logic              match;
    logic              shift;
    logic              last;

    always_comb begin
        pos   = USED_W'(i_idx);
        valid = pos < i_ctl.used;
        match = valid && (r_tag == i_ctl.key);
        shift = i_ctl.hit ? !i_link.found : (pos <= i_ctl.limit);
        last  = (pos + USED_W'(1)) == i_ctl.used;
        n_tag = (i_ctl.commit && shift) ? i_link.tag : r_tag;

        o_link.tag    = r_tag;
        o_link.found  = i_link.found | match;
        o_link.ev_tag = i_link.ev_tag | (last ? r_tag : '0);
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

endmodule

FILE: rtl/lbc_chain.sv
// Row of recency cells with the fill count; position 0 is the most recent.
// Depends on lbc_pkg and lbc_cell.
`timescale 1ns / 1ps

module lbc_chain import lbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BLK_W-1:0]  i_key,
    input  logic [USED_W-1:0] i_cap,
    input  logic              i_commit,
    output t_lookup           o_lookup
);

    logic [USED_W-1:0] r_used;
    logic [USED_W-1:0] n_used;
    logic              full;
    logic              hit;
    t_cell_ctl         ctl;
    t_link             links [CACHE_ENTRIES + 1];

    assign links[0] = '{tag: i_key, found: 1'b0, ev_tag: '0};

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        lbc_cell u_cell (
            .i_clk  (i_clk),
            .i_idx  (IDX_W'(g)),
            .i_ctl  (ctl),
            .i_link (links[g]),
            .o_link (links[g + 1])
        );
    end

    always_comb begin
        hit        = links[CACHE_ENTRIES].found;
        full       = r_used >= i_cap;
        ctl.commit = i_commit;
        ctl.hit    = hit;
        ctl.used   = r_used;
        ctl.limit  = full ? (i_cap - USED_W'(1)) : r_used;
        ctl.key    = i_key;

        n_used = r_used;
        if (i_commit && !hit) begin
            n_used = full ? i_cap : (r_used + USED_W'(1));
        end

        o_lookup.hit           = hit;
        o_lookup.evicted       = !hit && full;
        o_lookup.evicted_block = (!hit && full) ? links[CACHE_ENTRIES].ev_tag : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

endmodule

FILE: tb/tb_lru_block_cache.sv
// Self-checking testbench for lru_block_cache: random and directed block accesses
// across several capacity settings and idling phases, checked against a local cache model.
// Depends on lbc_pkg, lbc_req_if, lbc_rsp_if and the lru_block_cache RTL.
`timescale 1ns / 1ps

module tb_lru_block_cache;
    import lbc_pkg::*;

    typedef struct packed {
        logic              mode;
        logic [BLK_W-1:0]  blk;
        logic [DATA_W-1:0] wdata;
    } t_cache_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              disk_read;
        logic              disk_write;
        logic              evicted;
        logic [BLK_W-1:0]  evicted_block;
    } t_cache_outcome;

    localparam int HOLD_CYCLES = 400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lbc_req_if req_if ();
    lbc_rsp_if rsp_if ();

    lru_block_cache u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [DATA_W-1:0] shadow_store [NUM_BLOCKS];
    logic [BLK_W-1:0]  shadow_tags [CACHE_ENTRIES];
    int                shadow_used;
    logic [CAP_W-1:0]  shadow_capacity;

    t_cache_access  pending_accesses [$];
    t_cache_outcome expected_outcomes [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int unsigned hold_left;
    int          mismatch_count;
    int          beat_count;
    int          hit_count;
    int          evict_count;

    function automatic t_cache_outcome predict_access(input t_cache_access acc);
        t_cache_outcome res;
        int             live_cap;
        int             pos;
        int             shift_from;
        res = '0;
        live_cap = int'(shadow_capacity);
        if (live_cap == 0) begin
            live_cap = 1;
        end
        if (live_cap > CACHE_ENTRIES) begin
            live_cap = CACHE_ENTRIES;
        end
        pos = -1;
        for (int i = 0; i < shadow_used; i++) begin
            if (pos < 0 && shadow_tags[i] == acc.blk) begin
                pos = i;
            end
        end
        if (pos >= 0) begin
            res.hit = 1'b1;
            shift_from = pos;
        end else begin
            if (shadow_used >= live_cap) begin
                res.evicted = 1'b1;
                res.evicted_block = shadow_tags[shadow_used - 1];
                shadow_used = live_cap - 1;
            end
            shift_from = shadow_used;
            shadow_used++;
            if (acc.mode == MODE_WRITE) begin
                res.disk_write = 1'b1;
            end else begin
                res.disk_read = 1'b1;
            end
        end
        if (shift_from > CACHE_ENTRIES - 1) begin
            shift_from = CACHE_ENTRIES - 1;
        end
        for (int i = shift_from; i > 0; i--) begin
            shadow_tags[i] = shadow_tags[i - 1];
        end
        shadow_tags[0] = acc.blk;
        if (acc.mode == MODE_WRITE) begin
            shadow_store[acc.blk] = acc.wdata;
        end
        res.read_data = shadow_store[acc.blk];
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_lru_block_cache NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin : request_driver
        t_cache_access seen;
        t_cache_access next_item;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                seen.mode = req_if.mode;
                seen.blk = req_if.block_number;
                seen.wdata = req_if.write_data;
                expected_outcomes.insert(expected_outcomes.size(), predict_access(seen));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_accesses.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.mode <= next_item.mode;
                    req_if.block_number <= next_item.blk;
                    req_if.write_data <= next_item.wdata;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_request) begin
            hold_left <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_cache_outcome want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                beat_count++;
                if (expected_outcomes.size() == 0) begin
                    $error("result beat with no access outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    hit_count += want.hit;
                    evict_count += want.evicted;
                    compare_field("read_data", want.read_data, rsp_if.read_data);
                    compare_field("hit", want.hit, rsp_if.hit);
                    compare_field("disk_read", want.disk_read, rsp_if.disk_read);
                    compare_field("disk_write", want.disk_write, rsp_if.disk_write);
                    compare_field("evicted", want.evicted, rsp_if.evicted);
                    compare_field("evicted_block", want.evicted_block, rsp_if.evicted_block);
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_access(input logic mode, input int blk, input int data);
        t_cache_access acc;
        acc.mode = mode;
        acc.blk = BLK_W'(blk);
        acc.wdata = DATA_W'(data);
        pending_accesses.insert(pending_accesses.size(), acc);
    endtask

    task automatic fill_random(input int count, input int pool_size);
        int pool [128];
        int blk;
        for (int i = 0; i < pool_size; i++) begin
            pool[i] = $urandom_range(NUM_BLOCKS - 1);
        end
        pool[0] = 0;
        if (pool_size > 1) begin
            pool[1] = NUM_BLOCKS - 1;
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85) begin
                blk = pool[$urandom_range(pool_size - 1)];
            end else begin
                blk = $urandom_range(NUM_BLOCKS - 1);
            end
            push_access(1'($urandom_range(1)), blk, $urandom_range(255));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_accesses.size() != 0 || req_if.valid || expected_outcomes.size() != 0);
    endtask

    task automatic write_capacity(input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CAP_W'(value);
        shadow_capacity = CAP_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin : stimulus
        int rand_cap;
        int fresh_blk;
        bit cached;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_READ;
        req_if.block_number = '0;
        req_if.write_data = '0;
        rsp_if.ready = 1'b0;
        hold_request = 1'b0;
        mismatch_count = 0;
        beat_count = 0;
        hit_count = 0;
        evict_count = 0;
        shadow_used = 0;
        shadow_capacity = CAP_RESET;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            shadow_store[i] = '0;
        end
        set_idling(0, 0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_access(MODE_READ, 12'h000, 8'h00);
        push_access(MODE_WRITE, 12'hFFF, 8'hFF);
        push_access(MODE_READ, 12'hFFF, 8'h00);
        push_access(MODE_WRITE, 12'h000, 8'hA5);
        push_access(MODE_READ, 12'h000, 8'hFF);
        push_access(MODE_WRITE, 12'h800, 8'h00);
        push_access(MODE_READ, 12'h7FF, 8'h5A);
        push_access(MODE_WRITE, 12'h555, 8'h55);
        push_access(MODE_WRITE, 12'hAAA, 8'hAA);
        push_access(MODE_READ, 12'h555, 8'h00);
        push_access(MODE_WRITE, 12'hFFF, 8'h00);
        push_access(MODE_READ, 12'hFFF, 8'hFF);
        push_access(MODE_WRITE, 12'h001, 8'h80);
        push_access(MODE_READ, 12'h001, 8'h00);
        push_access(MODE_WRITE, 12'h7FF, 8'h7F);
        fill_random(230, 80);
        wait_idle();

        write_capacity(1);
        set_idling(64, 0);
        fill_random(200, 3);
        wait_idle();

        write_capacity(0);
        set_idling(0, 64);
        fill_random(200, 2);
        wait_idle();

        write_capacity(127);
        set_idling(21, 21);
        fill_random(250, 96);
        wait_idle();

        // Shrink the set below what is cached: deep entries still hit, then a miss cuts it.
        write_capacity(3);
        set_idling(0, 0);
        if (shadow_used > 4) begin
            push_access(MODE_READ, shadow_tags[shadow_used - 1], 0);
            push_access(MODE_WRITE, shadow_tags[shadow_used / 2], $urandom_range(255));
        end
        do begin
            fresh_blk = $urandom_range(NUM_BLOCKS - 1);
            cached = 1'b0;
            for (int i = 0; i < shadow_used; i++) begin
                if (shadow_tags[i] == fresh_blk) begin
                    cached = 1'b1;
                end
            end
        end while (cached);
        push_access(MODE_READ, fresh_blk, 0);
        fill_random(200, 5);
        wait_idle();

        write_capacity(65);
        set_idling(0, 0);
        hold_request = 1'b1;
        fill_random(200, 80);
        wait_idle();

        write_capacity(64);
        set_idling(64, 0);
        fill_random(200, 70);
        wait_idle();

        rand_cap = $urandom_range(2, 63);
        write_capacity(rand_cap);
        set_idling(21, 21);
        fill_random(200, rand_cap + rand_cap / 3 + 1);
        wait_idle();

        repeat (4) @(posedge i_clk);
        $display("Checked %0d result beats over capacities 0 to 127: %0d hits, %0d evictions.",
                 beat_count, hit_count, evict_count);
        if (mismatch_count == 0) begin
            $display("tb_lru_block_cache OK");
        end else begin
            $display("tb_lru_block_cache NOT OK");
        end
        $finish;
    end

endmodule
